### rtl/core/touch_event_tracker_macros.svh
// Assertion macros shared by the checker of touch_event_tracker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TOUCH_EVENT_TRACKER_MACROS_SVH
`define TOUCH_EVENT_TRACKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TET_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("touch_event_tracker: implication check failed");

// Next-cycle implication, checked outside reset.
`define TET_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("touch_event_tracker: next-cycle check failed");

`endif

### rtl/core/tet_pkg.sv
`timescale 1ns / 1ps

package tet_pkg;

    localparam int COORD_BITS = 12;
    localparam int SIZE_BITS  = COORD_BITS + 1;
    localparam int MAX_TOUCHES = 2;

    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    // Register indexes (byte address = 4 * index).
    localparam logic [2:0] REG_SWAP_AXES    = 3'd0;
    localparam logic [2:0] REG_INVERT_HORIZ = 3'd1;
    localparam logic [2:0] REG_INVERT_VERT  = 3'd2;
    localparam logic [2:0] REG_PANEL_WIDTH  = 3'd3;
    localparam logic [2:0] REG_PANEL_HEIGHT = 3'd4;

    localparam logic [SIZE_BITS-1:0] PANEL_SIZE_RESET = SIZE_BITS'(1 << COORD_BITS);

    // Event kinds.
    localparam logic [1:0] KIND_DOWN = 2'd0;
    localparam logic [1:0] KIND_MOVE = 2'd1;
    localparam logic [1:0] KIND_UP   = 2'd2;

    typedef enum logic
    {
        TOUCH_IDLE,
        TOUCH_HELD
    } touch_state_t;

    typedef struct packed
    {
        logic                 swap_axes;
        logic                 invert_horizontal;
        logic                 invert_vertical;
        logic [SIZE_BITS-1:0] panel_width;
        logic [SIZE_BITS-1:0] panel_height;
    } cfg_t;

    typedef struct packed
    {
        logic                  valid;
        logic [1:0]            kind;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } event_t;

endpackage

### rtl/core/tet_cfg_regs.sv
`timescale 1ns / 1ps

module tet_cfg_regs
    import tet_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign reg_index = paddr[ADDR_BITS-1:2];
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.swap_axes         <= 1'b0;
            cfg_reg.invert_horizontal <= 1'b0;
            cfg_reg.invert_vertical   <= 1'b0;
            cfg_reg.panel_width       <= PANEL_SIZE_RESET;
            cfg_reg.panel_height      <= PANEL_SIZE_RESET;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_SWAP_AXES:    cfg_reg.swap_axes         <= pwdata[0];
                REG_INVERT_HORIZ: cfg_reg.invert_horizontal <= pwdata[0];
                REG_INVERT_VERT:  cfg_reg.invert_vertical   <= pwdata[0];
                REG_PANEL_WIDTH:  cfg_reg.panel_width       <= pwdata[SIZE_BITS-1:0];
                REG_PANEL_HEIGHT: cfg_reg.panel_height      <= pwdata[SIZE_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_SWAP_AXES:    prdata = DATA_BITS'(cfg_reg.swap_axes);
            REG_INVERT_HORIZ: prdata = DATA_BITS'(cfg_reg.invert_horizontal);
            REG_INVERT_VERT:  prdata = DATA_BITS'(cfg_reg.invert_vertical);
            REG_PANEL_WIDTH:  prdata = DATA_BITS'(cfg_reg.panel_width);
            REG_PANEL_HEIGHT: prdata = DATA_BITS'(cfg_reg.panel_height);
            default:          prdata = '0;
        endcase
    end

endmodule

### rtl/core/tet_axis_map.sv
`timescale 1ns / 1ps

// Clamps one coordinate below the panel size and optionally mirrors it.
module tet_axis_map
    import tet_pkg::*;
(
    input  logic [COORD_BITS-1:0] raw,
    input  logic [SIZE_BITS-1:0]  size,
    input  logic                  invert,
    output logic [COORD_BITS-1:0] mapped
);

    logic [COORD_BITS-1:0] limit;
    logic [COORD_BITS-1:0] clamped;

    // limit is the effective size minus one; a size of zero acts as one and
    // anything above the full coordinate range acts as the full range.
    always_comb
    begin
        if (size == '0)
        begin
            limit = '0;
        end
        else if (size[SIZE_BITS-1])
        begin
            limit = '1;
        end
        else
        begin
            limit = size[COORD_BITS-1:0] - COORD_BITS'(1);
        end

        clamped = (raw > limit) ? limit : raw;
        mapped  = invert ? (limit - clamped) : clamped;
    end

endmodule

### rtl/core/tet_event_fsm.sv
`timescale 1ns / 1ps

// Holds the touch state and last point and decides which event a poll makes.
module tet_event_fsm
    import tet_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  read_ok,
    input  logic [3:0]            count,
    input  logic [COORD_BITS-1:0] px,
    input  logic [COORD_BITS-1:0] py,
    output event_t                evt
);

    touch_state_t          state_reg, state_next;
    logic [COORD_BITS-1:0] last_x_reg, last_x_next;
    logic [COORD_BITS-1:0] last_y_reg, last_y_next;
    logic                  poll_usable;

    assign poll_usable = read_ok && (count <= 4'(MAX_TOUCHES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= TOUCH_IDLE;
            last_x_reg <= '0;
            last_y_reg <= '0;
        end
        else if (step)
        begin
            state_reg  <= state_next;
            last_x_reg <= last_x_next;
            last_y_reg <= last_y_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        evt.valid   = 1'b0;
        evt.kind    = KIND_DOWN;
        evt.x       = px;
        evt.y       = py;

        if (poll_usable)
        begin
            case (state_reg)
                TOUCH_IDLE:
                begin
                    if (count != 4'd0)
                    begin
                        state_next  = TOUCH_HELD;
                        last_x_next = px;
                        last_y_next = py;
                        evt.valid   = 1'b1;
                        evt.kind    = KIND_DOWN;
                    end
                end
                TOUCH_HELD:
                begin
                    if (count == 4'd0)
                    begin
                        state_next = TOUCH_IDLE;
                        evt.valid  = 1'b1;
                        evt.kind   = KIND_UP;
                        evt.x      = last_x_reg;
                        evt.y      = last_y_reg;
                    end
                    else if ((px != last_x_reg) || (py != last_y_reg))
                    begin
                        last_x_next = px;
                        last_y_next = py;
                        evt.valid   = 1'b1;
                        evt.kind    = KIND_MOVE;
                    end
                end
                default:
                begin
                    state_next = TOUCH_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/core/touch_event_tracker.sv
`timescale 1ns / 1ps

// touch_event_tracker turns polls of a capacitive touch controller into DOWN,
// MOVE and UP events. A poll enters on the s_axis side (tuser carries the
// read-success flag, tdata the status byte and the four coordinate bytes) and
// is held in an input register; once the output register can take an event,
// the block maps the raw point (optional axis swap, clamp below the panel size,
// optional mirroring), compares it with the touch state and the last point,
// and loads any event into an output register that drives the m_axis side. One
// poll is accepted every cycle for as long as the output register is empty or
// being drained; a stalled output holds the input register, which is what sets
// the throughput. Polls with a failed read, or more than two touches, make no
// event and leave the state alone, as does a held touch whose mapped point has
// not changed. The mapping registers sit behind the APB port at byte addresses
// 0 (swap_axes), 4 (invert_horizontal), 8 (invert_vertical), 12 (panel_width)
// and 16 (panel_height); write them only while no poll is in flight.
module touch_event_tracker
    import tet_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    output logic [DATA_BITS-1:0]  prdata,
    output logic                  pready,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] status_byte, [15:8] x_high_byte, [23:16] x_low_byte,
    // [31:24] y_high_byte, [39:32] y_low_byte
    input  logic [39:0]           s_axis_tdata,
    // [0] read_ok
    input  logic                  s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [11:0] point_x, [23:12] point_y
    output logic [23:0]           m_axis_tdata,
    // [1:0] event_kind
    output logic [1:0]            m_axis_tuser
);

    cfg_t cfg;

    // Input register: one poll waiting to be evaluated.
    logic                  in_valid_reg, in_valid_next;
    logic                  read_ok_reg;
    logic [3:0]            count_reg;
    logic [COORD_BITS-1:0] raw_x_reg;
    logic [COORD_BITS-1:0] raw_y_reg;

    // Output register: one event waiting to be taken.
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            out_kind_reg;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;

    logic                  out_free;
    logic                  step;
    logic                  in_load;
    logic [COORD_BITS-1:0] axis_x;
    logic [COORD_BITS-1:0] axis_y;
    logic [COORD_BITS-1:0] map_x;
    logic [COORD_BITS-1:0] map_y;
    event_t                evt;

    tet_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The held poll is evaluated once the output register can take its event.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || step;
    assign in_load       = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = in_load ? 1'b1 : (step ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Only the low nibbles of the status and high coordinate bytes matter.
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            read_ok_reg <= s_axis_tuser;
            count_reg   <= s_axis_tdata[3:0];
            raw_x_reg   <= {s_axis_tdata[11:8], s_axis_tdata[23:16]};
            raw_y_reg   <= {s_axis_tdata[27:24], s_axis_tdata[39:32]};
        end
    end

    assign axis_x = cfg.swap_axes ? raw_y_reg : raw_x_reg;
    assign axis_y = cfg.swap_axes ? raw_x_reg : raw_y_reg;

    tet_axis_map u_map_x
    (
        .raw    (axis_x),
        .size   (cfg.panel_width),
        .invert (cfg.invert_horizontal),
        .mapped (map_x)
    );

    tet_axis_map u_map_y
    (
        .raw    (axis_y),
        .size   (cfg.panel_height),
        .invert (cfg.invert_vertical),
        .mapped (map_y)
    );

    tet_event_fsm u_event_fsm
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .read_ok (read_ok_reg),
        .count   (count_reg),
        .px      (map_x),
        .py      (map_y),
        .evt     (evt)
    );

    always_comb
    begin
        if (step && evt.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && evt.valid)
        begin
            out_kind_reg <= evt.kind;
            out_x_reg    <= evt.x;
            out_y_reg    <= evt.y;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_y_reg, out_x_reg};
    assign m_axis_tuser  = out_kind_reg;

endmodule

### rtl/core/tet_checker.sv
`timescale 1ns / 1ps
`include "touch_event_tracker_macros.svh"

// Port-level checks: a stalled output holds; events follow DOWN (MOVE)* UP.
module tet_checker
    import tet_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [23:0]          m_axis_tdata,
    input logic [1:0]           m_axis_tuser
);

    logic       out_take;
    logic       seen_reg;
    logic [1:0] prev_kind_reg;
    logic       touch_open;

    assign out_take   = m_axis_tvalid && m_axis_tready;
    assign touch_open = seen_reg && (prev_kind_reg != KIND_UP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            prev_kind_reg <= KIND_UP;
        end
        else if (out_take)
        begin
            seen_reg      <= 1'b1;
            prev_kind_reg <= m_axis_tuser;
        end
    end

    `TET_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `TET_ASSERT_IMP(a_down_when_closed, out_take && (m_axis_tuser == KIND_DOWN), !touch_open)
    `TET_ASSERT_IMP(a_move_when_open, out_take && (m_axis_tuser == KIND_MOVE), touch_open)
    `TET_ASSERT_IMP(a_up_when_open, out_take && (m_axis_tuser == KIND_UP), touch_open)

endmodule

bind touch_event_tracker tet_checker u_tet_checker (.*);
